FILE: sv/xmodem_block_receiver_macros.svh
// Assertion macros shared by the receiver RTL.
// Compile with ASSERT_OFF to drop every check.
`ifndef XMODEM_BLOCK_RECEIVER_MACROS_SVH
`define XMODEM_BLOCK_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at each rising edge out of reset.
`define XBR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xbr: assertion failed");

// Next-cycle implication.
`define XBR_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xbr: assertion failed");

`else

`define XBR_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define XBR_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/xbr_pkg.sv
`timescale 1ns / 1ps

package xbr_pkg;

	localparam int BLOCK_BYTES_DEF = 128;

	// Event codes on the request channel
	localparam logic [1:0] FN_START   = 2'd0;
	localparam logic [1:0] FN_BYTE    = 2'd1;
	localparam logic [1:0] FN_TIMEOUT = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_REPLY = 2'd0;
	localparam logic [1:0] KIND_WORD  = 2'd1;
	localparam logic [1:0] KIND_FAIL  = 2'd2;

	// Protocol bytes
	localparam logic [7:0] SOH_BYTE = 8'h01;
	localparam logic [7:0] EOT_BYTE = 8'h04;
	localparam logic [7:0] ACK_BYTE = 8'h06;
	localparam logic [7:0] NAK_BYTE = 8'h15;
	localparam logic [7:0] CRC_HDR  = 8'h43;

	// Configuration register indexes
	localparam logic REG_RETRY_LIMIT = 1'b0;
	localparam logic REG_CRC_POLY    = 1'b1;

	localparam logic [7:0]  RETRY_LIMIT_RST = 8'd7;
	localparam logic [15:0] CRC_POLY_RST    = 16'h1021;

	// Output register load sources
	localparam logic [1:0] OSEL_NEW  = 2'd0;
	localparam logic [1:0] OSEL_PEND = 2'd1;
	localparam logic [1:0] OSEL_WORD = 2'd2;
	localparam logic [1:0] OSEL_FAIL = 2'd3;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic [63:0] data_word;
		logic        finished;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic        index;
		logic [15:0] data;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic       in_take;
		logic       hdr_init;
		logic       body_acc;
		logic       word_shift;
		logic       word_wr;
		logic       check_shift;
		logic       att_one;
		logic       att_inc;
		logic       pend_load;
		logic       ram_ren;
		logic       out_load;
		logic [1:0] out_sel;
		logic [7:0] reply;
		logic       fin;
		logic       last;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
		logic       crc_mode;
		logic       good;
		logic       retry_hit;
		logic       out_free;
	} status_t;

	// One byte into a CRC-16, MSB first
	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b,
		input logic [15:0] poly);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: sv/xbr_stream_if.sv
`timescale 1ns / 1ps

interface xbr_req_if;
	import xbr_pkg::*;
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface xbr_rsp_if;
	import xbr_pkg::*;
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface xbr_cfg_if;
	import xbr_pkg::*;
	logic valid;
	logic ready;
	cfg_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/xbr_ram.sv
`timescale 1ns / 1ps

module xbr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/xbr_dp.sv
`timescale 1ns / 1ps

module xbr_dp #(
	parameter int BLOCK_BYTES = xbr_pkg::BLOCK_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  xbr_pkg::req_t                        in_data,
	input  xbr_pkg::cmd_t                        cmd,
	input  logic [$clog2(BLOCK_BYTES/8)-1:0]     mem_addr,
	output xbr_pkg::status_t                     status,
	xbr_rsp_if.source                            rsp,
	xbr_cfg_if.sink                              cfg
);
	import xbr_pkg::*;

	localparam int WORDS = BLOCK_BYTES / 8;

	req_t        in_q;
	logic        crc_mode_q;
	logic [7:0]  sum_q;
	logic [15:0] crc_q;
	logic [15:0] check_q;
	logic [63:0] word_q;
	logic [7:0]  att_q;
	logic [7:0]  pend_q;
	logic [7:0]  retry_limit_q;
	logic [15:0] poly_q;
	logic        out_valid_q;
	rsp_t        out_q;
	logic [63:0] word_next;
	logic [63:0] rdata;
	rsp_t        out_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
			poly_q        <= CRC_POLY_RST;
		end else if (cfg.valid) begin
			unique case (cfg.payload.index)
				REG_RETRY_LIMIT: retry_limit_q <= cfg.payload.data[7:0];
				REG_CRC_POLY:    poly_q        <= cfg.payload.data;
				default:         poly_q        <= poly_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.in_take) begin
			in_q <= in_data;
		end
	end

	assign word_next = {in_q.rx_byte, word_q[63:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_mode_q <= 1'b0;
			sum_q      <= '0;
			crc_q      <= '0;
			check_q    <= '0;
			att_q      <= '0;
			pend_q     <= NAK_BYTE;
		end else begin
			if (cmd.hdr_init) begin
				crc_mode_q <= (in_q.rx_byte == CRC_HDR);
				sum_q      <= in_q.rx_byte;
				crc_q      <= crc_add(16'h0000, in_q.rx_byte, poly_q);
				check_q    <= '0;
			end
			if (cmd.body_acc) begin
				sum_q <= sum_q + in_q.rx_byte;
				crc_q <= crc_add(crc_q, in_q.rx_byte, poly_q);
			end
			if (cmd.check_shift) begin
				check_q <= {check_q[7:0], in_q.rx_byte};
			end
			if (cmd.att_one) begin
				att_q <= 8'd1;
			end else if (cmd.att_inc) begin
				att_q <= att_q + 8'd1;
			end
			if (cmd.pend_load) begin
				pend_q <= cmd.reply;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.word_shift) begin
			word_q <= word_next;
		end
	end

	xbr_ram #(
		.WIDTH(64),
		.DEPTH(WORDS)
	) u_store (
		.clk   (clk),
		.we    (cmd.word_wr),
		.waddr (mem_addr),
		.wdata (word_next),
		.re    (cmd.ram_ren),
		.raddr (mem_addr),
		.rdata (rdata)
	);

	always_comb begin
		out_d          = '0;
		out_d.last     = cmd.last;
		unique case (cmd.out_sel)
			OSEL_NEW: begin
				out_d.kind     = KIND_REPLY;
				out_d.tx_byte  = cmd.reply;
				out_d.finished = cmd.fin;
			end
			OSEL_PEND: begin
				out_d.kind    = KIND_REPLY;
				out_d.tx_byte = pend_q;
			end
			OSEL_WORD: begin
				out_d.kind      = KIND_WORD;
				out_d.data_word = rdata;
			end
			OSEL_FAIL: begin
				out_d.kind = KIND_FAIL;
			end
			default: out_d.kind = KIND_FAIL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= out_d;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

	assign status.func      = in_q.func;
	assign status.rx_byte   = in_q.rx_byte;
	assign status.crc_mode  = crc_mode_q;
	assign status.good      = crc_mode_q ? (check_q == crc_q) : (check_q[7:0] == sum_q);
	assign status.retry_hit = (att_q >= retry_limit_q);
	assign status.out_free  = !out_valid_q || rsp.ready;

endmodule

FILE: sv/xbr_ctrl.sv
`timescale 1ns / 1ps

module xbr_ctrl #(
	parameter int BLOCK_BYTES = xbr_pkg::BLOCK_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  xbr_pkg::status_t                 status,
	output xbr_pkg::cmd_t                    cmd,
	output logic [$clog2(BLOCK_BYTES/8)-1:0] mem_addr
);
	import xbr_pkg::*;

	localparam int WORDS = BLOCK_BYTES / 8;
	localparam int AW    = $clog2(WORDS);
	localparam int IDX_W = $clog2(BLOCK_BYTES + 5);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EXEC  = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_READ  = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;
	localparam logic [2:0] ST_ACK   = 3'd5;

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_WAIT = 3'd1;
	localparam logic [2:0] PH_BODY = 3'd2;
	localparam logic [2:0] PH_DONE = 3'd3;
	localparam logic [2:0] PH_FAIL = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [2:0]       phase_q, phase_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [AW-1:0]    wcnt_q, wcnt_d;
	logic [IDX_W-1:0] d_full;
	logic [IDX_W-1:0] idx_inc;
	logic [IDX_W-1:0] total;

	assign d_full  = idx_q - IDX_W'(2);
	assign idx_inc = idx_q + IDX_W'(1);
	assign total   = status.crc_mode ? IDX_W'(BLOCK_BYTES + 4) : IDX_W'(BLOCK_BYTES + 3);
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd      = '0;
		mem_addr = '0;
		state_d  = state_q;
		phase_d  = phase_q;
		idx_d    = idx_q;
		wcnt_d   = wcnt_q;
		cmd.in_take = in_valid && (state_q == ST_IDLE);

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				unique case (status.func)
					FN_START: begin
						if (status.out_free) begin
							cmd.out_load  = 1'b1;
							cmd.out_sel   = OSEL_NEW;
							cmd.reply     = NAK_BYTE;
							cmd.last      = 1'b1;
							cmd.pend_load = 1'b1;
							cmd.att_one   = 1'b1;
							phase_d       = PH_WAIT;
							idx_d         = '0;
						end else begin
							state_d = ST_EXEC;
						end
					end
					FN_BYTE: begin
						if (phase_q == PH_WAIT) begin
							priority if (status.rx_byte == SOH_BYTE ||
								status.rx_byte == CRC_HDR) begin
								cmd.hdr_init = 1'b1;
								idx_d        = '0;
								phase_d      = PH_BODY;
							end else if (!status.out_free) begin
								state_d = ST_EXEC;
							end else if (status.rx_byte == EOT_BYTE) begin
								cmd.out_load  = 1'b1;
								cmd.out_sel   = OSEL_NEW;
								cmd.reply     = ACK_BYTE;
								cmd.fin       = 1'b1;
								cmd.last      = 1'b1;
								cmd.pend_load = 1'b1;
								phase_d       = PH_DONE;
							end else begin
								cmd.out_load  = 1'b1;
								cmd.out_sel   = OSEL_NEW;
								cmd.reply     = NAK_BYTE;
								cmd.last      = 1'b1;
								cmd.pend_load = 1'b1;
								cmd.att_one   = 1'b1;
							end
						end else if (phase_q == PH_BODY) begin
							if (idx_q < IDX_W'(BLOCK_BYTES + 2)) begin
								cmd.body_acc = 1'b1;
								if (idx_q >= IDX_W'(2)) begin
									cmd.word_shift = 1'b1;
									cmd.word_wr    = (d_full[2:0] == 3'h7);
									mem_addr       = d_full[AW+2:3];
								end
							end else begin
								cmd.check_shift = 1'b1;
							end
							idx_d = idx_inc;
							if (idx_inc == total) begin
								state_d = ST_CHECK;
							end
						end
					end
					FN_TIMEOUT: begin
						if (phase_q == PH_WAIT) begin
							if (!status.out_free) begin
								state_d = ST_EXEC;
							end else if (status.retry_hit) begin
								cmd.out_load = 1'b1;
								cmd.out_sel  = OSEL_FAIL;
								cmd.last     = 1'b1;
								phase_d      = PH_FAIL;
							end else begin
								cmd.out_load = 1'b1;
								cmd.out_sel  = OSEL_PEND;
								cmd.last     = 1'b1;
								cmd.att_inc  = 1'b1;
							end
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_CHECK: begin
				phase_d = PH_WAIT;
				if (status.good) begin
					state_d = ST_READ;
				end else if (status.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_sel   = OSEL_NEW;
					cmd.reply     = NAK_BYTE;
					cmd.last      = 1'b1;
					cmd.pend_load = 1'b1;
					cmd.att_one   = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.ram_ren = 1'b1;
				mem_addr    = '0;
				wcnt_d      = '0;
				state_d     = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = OSEL_WORD;
					cmd.ram_ren  = 1'b1;
					mem_addr     = wcnt_q + AW'(1);
					wcnt_d       = wcnt_q + AW'(1);
					if (wcnt_q == AW'(WORDS - 1)) begin
						state_d = ST_ACK;
					end
				end
			end
			ST_ACK: begin
				if (status.out_free) begin
					cmd.out_load  = 1'b1;
					cmd.out_sel   = OSEL_NEW;
					cmd.reply     = ACK_BYTE;
					cmd.last      = 1'b1;
					cmd.pend_load = 1'b1;
					cmd.att_one   = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			wcnt_q  <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			idx_q   <= idx_d;
			wcnt_q  <= wcnt_d;
		end
	end

endmodule

FILE: sv/xmodem_block_receiver.sv
`timescale 1ns / 1ps
`include "xmodem_block_receiver_macros.svh"

// Channel  Dir   Payload                                       Transaction
// -------  ----  --------------------------------------------  ----------------------
// req      in    func, rx_byte                                 valid & ready at clk
// rsp      out   kind, tx_byte, data_word, finished, last      valid & ready at clk
// cfg      in    index (0 retry_limit, 1 crc_polynomial), data valid & ready, ready = 1
//
// An event is accepted in the idle state and executed in the execute state, which waits
// while its result finds the output register full; a header or body byte costs one
// CRC-16 byte step (eight bit steps) there. The last byte of a frame leads to a check
// state. A good block then reads the word store (single RAM, registered read): a read
// state primes word 0, drain sends one word per cycle while rsp is free, then the ACK.
// Results sit in one output register; a stalled rsp holds the sequencer in place.
// arst_n resets to the idle phase, retry limit 7, polynomial 0x1021, pending reply NAK.
module xmodem_block_receiver #(
	parameter int BLOCK_BYTES = xbr_pkg::BLOCK_BYTES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	xbr_req_if.sink   req,
	xbr_rsp_if.source rsp,
	xbr_cfg_if.sink   cfg
);
	import xbr_pkg::*;

	localparam int AW = $clog2(BLOCK_BYTES / 8);

	cmd_t          cmd;
	status_t       status;
	logic [AW-1:0] mem_addr;
	logic          in_ready;

	assign req.ready = in_ready;

	// Sequencer: protocol phase, byte index, word drain count
	xbr_ctrl #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd),
		.mem_addr (mem_addr)
	);

	// Checks, word store, retry state, config registers and the result register
	xbr_dp #(
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (req.payload),
		.cmd      (cmd),
		.mem_addr (mem_addr),
		.status   (status),
		.rsp      (rsp),
		.cfg      (cfg)
	);

	// Drop ready for the execute cycle after each accepted transaction
	`XBR_ASSERT_NXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	// Never overwrite a result that has not been taken
	`XBR_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, status.out_free)
	// A data word is always followed by the ACK, so it never closes an event
	`XBR_ASSERT_IMP(a_word_not_last, clk, arst_n,
		rsp.valid && rsp.payload.kind == KIND_WORD, !rsp.payload.last)
	// A failure report stands alone
	`XBR_ASSERT_IMP(a_fail_last, clk, arst_n,
		rsp.valid && rsp.payload.kind == KIND_FAIL, rsp.payload.last)

endmodule

FILE: tb/sv/xmodem_block_receiver_tb.sv
`timescale 1ns / 1ps

module xmodem_block_receiver_tb;
	import xbr_pkg::*;

	localparam int WORDS = BLOCK_BYTES_DEF / 8;

	// Receiver phases as tracked on the testbench side
	typedef enum logic [2:0] {
		RXP_IDLE,
		RXP_HEADER,
		RXP_BODY,
		RXP_DONE,
		RXP_FAILED
	} rx_phase_e;

	// Tracks the receiver state and holds the results that each accepted event must produce.
	class rx_block_tracker;
		rsp_t        awaited_results[$];
		int unsigned failures;
		logic [7:0]  retry_lim;
		logic [15:0] poly;
		rx_phase_e   phase;
		bit          crc_mode;
		int unsigned byte_index;
		logic [7:0]  run_sum;
		logic [15:0] run_crc;
		logic [63:0] words[WORDS];
		logic [15:0] check_bytes;
		logic [7:0]  attempts;
		logic [7:0]  pending;

		function new();
			failures    = 0;
			retry_lim   = RETRY_LIMIT_RST;
			poly        = CRC_POLY_RST;
			phase       = RXP_IDLE;
			crc_mode    = 1'b0;
			byte_index  = 0;
			run_sum     = 8'h00;
			run_crc     = 16'h0000;
			check_bytes = 16'h0000;
			attempts    = 8'h00;
			pending     = NAK_BYTE;
		endfunction

		// Bitwise CRC-16 update, MSB first, with the current polynomial
		function logic [15:0] crc_step(logic [15:0] acc, logic [7:0] b);
			logic [15:0] r;
			logic        fb;
			r = acc;
			for (int k = 7; k >= 0; k--) begin
				fb = r[15] ^ b[k];
				r  = {r[14:0], 1'b0};
				if (fb) begin
					r = r ^ poly;
				end
			end
			return r;
		endfunction

		function void set_register(logic idx, logic [15:0] data);
			if (idx == REG_RETRY_LIMIT) begin
				retry_lim = data[7:0];
			end else begin
				poly = data;
			end
		endfunction

		function void emit(logic [1:0] k, logic [7:0] tx, logic [63:0] wd, logic fin);
			awaited_results.push_back('{kind: k, tx_byte: tx, data_word: wd, finished: fin,
				last: 1'b0});
		endfunction

		function void answer(logic [7:0] reply);
			pending  = reply;
			attempts = 8'd1;
			emit(KIND_REPLY, reply, 64'h0, 1'b0);
		endfunction

		function void take_header(logic [7:0] b);
			if (b == SOH_BYTE || b == CRC_HDR) begin
				crc_mode    = (b == CRC_HDR);
				byte_index  = 0;
				run_sum     = b;
				run_crc     = crc_step(16'h0000, b);
				check_bytes = 16'h0000;
				phase       = RXP_BODY;
			end else if (b == EOT_BYTE) begin
				pending = ACK_BYTE;
				emit(KIND_REPLY, ACK_BYTE, 64'h0, 1'b1);
				phase = RXP_DONE;
			end else begin
				answer(NAK_BYTE);
			end
		endfunction

		function void take_body(logic [7:0] b);
			int unsigned total;
			int unsigned d;
			int unsigned w;
			bit          good;
			total = crc_mode ? BLOCK_BYTES_DEF + 4 : BLOCK_BYTES_DEF + 3;
			if (byte_index < BLOCK_BYTES_DEF + 2) begin
				run_sum = run_sum + b;
				run_crc = crc_step(run_crc, b);
				if (byte_index >= 2) begin
					d = byte_index - 2;
					w = (d >> 3) % WORDS;
					if (d % 8 == 0) begin
						words[w] = 64'h0;
					end
					words[w][(d % 8) * 8 +: 8] = b;
				end
			end else begin
				check_bytes = {check_bytes[7:0], b};
			end
			byte_index++;
			if (byte_index < total) begin
				return;
			end
			good = crc_mode ? (check_bytes == run_crc) : (check_bytes[7:0] == run_sum);
			if (good) begin
				for (int k = 0; k < WORDS; k++) begin
					emit(KIND_WORD, 8'h00, words[k], 1'b0);
				end
				answer(ACK_BYTE);
			end else begin
				answer(NAK_BYTE);
			end
			phase = RXP_HEADER;
		endfunction

		// Note one accepted event; return whether the receiver acts on it at all.
		function bit note_event(req_t ev);
			int unsigned before_n;
			bit          acted;
			rsp_t        tail;
			before_n = awaited_results.size();
			acted    = 1'b0;
			case (ev.func)
				FN_START: begin
					phase      = RXP_HEADER;
					byte_index = 0;
					answer(NAK_BYTE);
					acted = 1'b1;
				end
				FN_BYTE: begin
					acted = (phase == RXP_HEADER || phase == RXP_BODY);
					if (phase == RXP_HEADER) begin
						take_header(ev.rx_byte);
					end else if (phase == RXP_BODY) begin
						take_body(ev.rx_byte);
					end
				end
				FN_TIMEOUT: begin
					if (phase == RXP_HEADER) begin
						acted = 1'b1;
						if (attempts >= retry_lim) begin
							emit(KIND_FAIL, 8'h00, 64'h0, 1'b0);
							phase = RXP_FAILED;
						end else begin
							attempts++;
							emit(KIND_REPLY, pending, 64'h0, 1'b0);
						end
					end
				end
				default: ;
			endcase
			// Flag the final result of this event
			if (awaited_results.size() > before_n) begin
				tail      = awaited_results.pop_back();
				tail.last = 1'b1;
				awaited_results.push_back(tail);
			end
			return acted;
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d tx %h word %h",
					$time, got.kind, got.tx_byte, got.data_word);
				failures++;
				return;
			end
			want = awaited_results.pop_front();
			if (got.kind !== want.kind) begin
				$display("%0t: kind mismatch, expected %0d, actual %0d",
					$time, want.kind, got.kind);
				failures++;
			end
			if (got.tx_byte !== want.tx_byte) begin
				$display("%0t: tx_byte mismatch, expected %h, actual %h",
					$time, want.tx_byte, got.tx_byte);
				failures++;
			end
			if (got.data_word !== want.data_word) begin
				$display("%0t: data_word mismatch, expected %h, actual %h",
					$time, want.data_word, got.data_word);
				failures++;
			end
			if (got.finished !== want.finished) begin
				$display("%0t: finished mismatch, expected %b, actual %b",
					$time, want.finished, got.finished);
				failures++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last mismatch, expected %b, actual %b",
					$time, want.last, got.last);
				failures++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	xbr_req_if req_bus ();
	xbr_rsp_if rsp_bus ();
	xbr_cfg_if cfg_bus ();

	xmodem_block_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	rx_block_tracker tracker;
	bit              quiet;        // no idling on either side when set
	int unsigned     acted_items;  // events the receiver acted on
	int unsigned     stall_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every result transaction against the oldest awaited one.
	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			tracker.check_result(rsp_bus.payload);
		end
	end

	// Stall the result side in random bursts; hold ready high in quiet mode.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_bus.ready <= 1'b0;
			stall_left    <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			rsp_bus.ready <= 1'b0;
			stall_left    <= $urandom_range(0, 2);
		end else begin
			rsp_bus.ready <= 1'b1;
		end
	end

	// Drive one event; entered and left at a falling edge. Valid stays high between
	// back-to-back events and drops only for an idle burst.
	task automatic send_event(logic [1:0] f, logic [7:0] b);
		req_t ev;
		ev = '{func: f, rx_byte: b};
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_bus.valid   <= 1'b1;
		req_bus.payload <= ev;
		do @(posedge clk); while (!req_bus.ready);
		if (tracker.note_event(ev)) begin
			acted_items++;
		end
		@(negedge clk);
	endtask

	// Drop valid, drain every awaited result, then give in-flight events time to finish.
	task automatic settle();
		req_bus.valid <= 1'b0;
		while (tracker.awaited_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// Write both registers back to back; call only while the receiver is idle.
	task automatic program_settings(logic [7:0] lim, logic [15:0] poly);
		cfg_bus.valid   <= 1'b1;
		cfg_bus.payload <= '{index: REG_RETRY_LIMIT, data: {8'h00, lim}};
		do @(posedge clk); while (!cfg_bus.ready);
		tracker.set_register(REG_RETRY_LIMIT, {8'h00, lim});
		@(negedge clk);
		cfg_bus.payload <= '{index: REG_CRC_POLY, data: poly};
		do @(posedge clk); while (!cfg_bus.ready);
		tracker.set_register(REG_CRC_POLY, poly);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Send a complete frame: header, block number, complement, data and check.
	// A damaged frame gets a corrupted check so the receiver must NAK it.
	task automatic send_block(bit use_crc, bit intact);
		logic [7:0]  hdr;
		logic [7:0]  blk_num;
		logic [7:0]  b;
		logic [7:0]  sum;
		logic [15:0] crc;
		hdr     = use_crc ? CRC_HDR : SOH_BYTE;
		blk_num = 8'($urandom);
		sum     = hdr;
		crc     = tracker.crc_step(16'h0000, hdr);
		send_event(FN_BYTE, hdr);
		for (int i = 0; i < BLOCK_BYTES_DEF + 2; i++) begin
			case (i)
				0: b = blk_num;
				1: b = ~blk_num;
				default: begin
					case ($urandom_range(0, 7))
						0: b = 8'h00;
						1: b = 8'hFF;
						default: b = 8'($urandom);
					endcase
				end
			endcase
			sum = sum + b;
			crc = tracker.crc_step(crc, b);
			send_event(FN_BYTE, b);
			// A timeout inside a body must be ignored
			if ($urandom_range(0, 31) == 0) begin
				send_event(FN_TIMEOUT, 8'($urandom));
			end
		end
		if (!intact) begin
			sum = sum ^ 8'($urandom_range(1, 255));
			crc = crc ^ 16'($urandom_range(1, 65535));
		end
		if (use_crc) begin
			send_event(FN_BYTE, crc[15:8]);
			send_event(FN_BYTE, crc[7:0]);
		end else begin
			send_event(FN_BYTE, sum);
		end
	endtask

	// Random short episodes until the budget of acted events is spent, plus the given
	// number of complete frames mixed in among them.
	task automatic run_random(int unsigned budget, int unsigned frames);
		int unsigned first;
		int unsigned frames_left;
		int unsigned pick;
		first       = acted_items;
		frames_left = frames;
		while (acted_items - first < budget || frames_left > 0) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3 && frames_left == 0) begin
				pick = 9;
			end
			case (pick)
				0, 1, 2, 3: begin
					frames_left--;
					if (tracker.phase != RXP_HEADER || $urandom_range(0, 1) == 0) begin
						send_event(FN_START, 8'($urandom));
					end
					send_block(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
				end
				4: begin
					// Abort a frame part way through the body
					send_event(FN_START, 8'($urandom));
					send_event(FN_BYTE, $urandom_range(0, 1) ? CRC_HDR : SOH_BYTE);
					repeat ($urandom_range(1, 20)) send_event(FN_BYTE, 8'($urandom));
					send_event(FN_START, 8'($urandom));
				end
				5, 6: begin
					repeat ($urandom_range(1, 4)) send_event(FN_TIMEOUT, 8'($urandom));
				end
				7: begin
					if (tracker.phase != RXP_HEADER || $urandom_range(0, 1) == 0) begin
						send_event(FN_START, 8'($urandom));
					end
					send_event(FN_BYTE, EOT_BYTE);
				end
				8: begin
					repeat ($urandom_range(1, 4)) begin
						send_event(2'($urandom_range(0, 3)), 8'($urandom));
					end
				end
				default: send_event(FN_START, 8'($urandom));
			endcase
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		quiet           = 1'b0;
		acted_items     = 0;
		stall_left      = 0;
		req_bus.valid   = 1'b0;
		req_bus.payload = '0;
		cfg_bus.valid   = 1'b0;
		cfg_bus.payload = '0;
		rsp_bus.ready   = 1'b0;
		tracker         = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at reset settings.
		// Events before any start are ignored, as is the unused function code.
		send_event(FN_BYTE, SOH_BYTE);
		send_event(FN_TIMEOUT, 8'h00);
		send_event(2'd3, 8'hFF);
		// Start, unknown headers, a resend on timeout, then EOT closes the transfer
		send_event(FN_START, 8'h00);
		send_event(FN_BYTE, 8'hFF);
		send_event(FN_BYTE, 8'h00);
		send_event(FN_TIMEOUT, 8'hFF);
		send_event(FN_BYTE, EOT_BYTE);
		// Done phase ignores everything but a start
		send_event(FN_BYTE, SOH_BYTE);
		send_event(FN_TIMEOUT, 8'h55);
		// Timeout and the unused code inside a body are ignored; a start aborts the body
		send_event(FN_START, 8'hAA);
		send_event(FN_BYTE, SOH_BYTE);
		send_event(FN_TIMEOUT, 8'h00);
		send_event(2'd3, 8'h00);
		send_event(FN_BYTE, 8'hAA);
		send_event(FN_BYTE, 8'h55);
		send_event(FN_START, 8'h00);
		// Exhaust the default retry limit into the failed phase
		repeat (7) send_event(FN_TIMEOUT, 8'($urandom));
		send_event(FN_TIMEOUT, 8'h00);
		// Start recovers from the failed phase; abort a CRC frame right after its header
		send_event(FN_START, 8'hFF);
		send_event(FN_BYTE, CRC_HDR);
		send_event(FN_START, 8'h00);
		settle();

		// Retry limit zero fails on the first timeout; all-ones polynomial
		program_settings(8'd0, 16'hFFFF);
		run_random(15, 0);
		settle();

		// Widest retry limit; zero polynomial
		program_settings(8'd255, 16'h0000);
		run_random(15, 0);
		settle();

		// One complete frame under result stalls
		program_settings(8'd1, 16'h8005);
		run_random(10, 1);
		settle();

		// Last stretch runs with no idling on either side
		quiet = 1'b1;
		program_settings(8'($urandom_range(2, 9)), 16'($urandom));
		run_random(15, 0);
		settle();

		if (tracker.failures == 0 && tracker.awaited_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Hard stop in case the receiver hangs
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
